// ===== rtl/core/assert_macros.svh =====
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked on every clock edge outside reset
`define ASSERT_IMPL(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/core/qrv_pkg.sv =====
package qrv_pkg;

	localparam int COMP_WIDTH = 16;
	localparam int FRAC_BITS  = 14;

	// first hamilton product terms and their sums
	localparam int PROD_W = 2 * COMP_WIDTH;
	localparam int T_W    = 2 * COMP_WIDTH + 1;
	// second product terms and the four-term sums
	localparam int QP_W   = T_W + COMP_WIDTH;
	localparam int R_W    = QP_W + 2;

	localparam int SHIFT  = 2 * FRAC_BITS;
	localparam int SH_W   = (R_W - SHIFT + 1 > COMP_WIDTH + 1) ?
		(R_W - SHIFT + 1) : (COMP_WIDTH + 1);
	localparam int ACC_W  = SHIFT + SH_W;

	typedef logic signed [COMP_WIDTH-1:0] comp_t;
	typedef logic signed [PROD_W-1:0]     prod_t;
	typedef logic signed [T_W-1:0]        tsum_t;
	typedef logic signed [QP_W-1:0]       qprod_t;
	typedef logic signed [R_W-1:0]        rsum_t;

	localparam logic signed [ACC_W-1:0] ROUND_HALF = ACC_W'(1) << (SHIFT - 1);
	localparam logic signed [SH_W-1:0]  SAT_MAX =
		{{(SH_W-COMP_WIDTH+1){1'b0}}, {(COMP_WIDTH-1){1'b1}}};
	localparam logic signed [SH_W-1:0]  SAT_MIN = ~SAT_MAX;
	localparam comp_t COMP_MAX = {1'b0, {(COMP_WIDTH-1){1'b1}}};
	localparam comp_t COMP_MIN = {1'b1, {(COMP_WIDTH-1){1'b0}}};

endpackage

// ===== rtl/core/qrv_in_if.sv =====
interface qrv_in_if import qrv_pkg::*; ();
	logic  valid;
	logic  ready;
	comp_t quat_w;
	comp_t quat_x;
	comp_t quat_y;
	comp_t quat_z;
	comp_t vec_x;
	comp_t vec_y;
	comp_t vec_z;

	modport source (output valid, output quat_w, output quat_x, output quat_y,
		output quat_z, output vec_x, output vec_y, output vec_z, input ready);
	modport sink (input valid, input quat_w, input quat_x, input quat_y,
		input quat_z, input vec_x, input vec_y, input vec_z, output ready);
endinterface

// ===== rtl/core/qrv_out_if.sv =====
interface qrv_out_if import qrv_pkg::*; ();
	logic  valid;
	logic  ready;
	comp_t rot_x;
	comp_t rot_y;
	comp_t rot_z;
	logic  clipped;

	modport source (output valid, output rot_x, output rot_y, output rot_z,
		output clipped, input ready);
	modport sink (input valid, input rot_x, input rot_y, input rot_z,
		input clipped, output ready);
endinterface

// ===== rtl/core/qrv_round_sat.sv =====
module qrv_round_sat import qrv_pkg::*; (
	input  rsum_t acc,
	output comp_t rot,
	output logic  clip
);

	logic signed [ACC_W-1:0] rnd;
	logic signed [SH_W-1:0]  sh;

	// round half up, then drop the fraction bits
	assign rnd = ACC_W'(acc) + ROUND_HALF;
	assign sh  = rnd[ACC_W-1:SHIFT];

	always_comb begin
		clip = (sh > SAT_MAX) || (sh < SAT_MIN);
		if (clip) begin
			rot = sh[SH_W-1] ? COMP_MIN : COMP_MAX;
		end else begin
			rot = sh[COMP_WIDTH-1:0];
		end
	end

endmodule

// ===== rtl/core/quaternion_rotate_vector.sv =====
// rotates a vector by q * (0,v) * conj(q), exact products, rounded and saturated
// an item moves from stage 1 through stage 5; stage 5 is the output register
// throughput: one item per cycle while dout is ready; five register stages, each
//   stage stalls only when it holds an item and the stage after it cannot take one
// reset clears the stage valid bits only; payload registers are not reset
`include "assert_macros.svh"

module quaternion_rotate_vector import qrv_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	qrv_in_if.sink     din,
	qrv_out_if.source  dout
);

	logic v_s1, v_s2, v_s3, v_s4, v_s5;
	logic en_s1, en_s2, en_s3, en_s4, en_s5;

	comp_t  q_s1 [4];
	prod_t  p_s1 [12];
	comp_t  q_s2 [4];
	tsum_t  t_s2 [4];
	qprod_t qp_s3 [12];
	rsum_t  r_s4 [3];
	comp_t  rot_s5 [3];
	logic   clip_s5;

	comp_t  rot_c [3];
	logic   clip_c [3];

	// a stage loads when it is empty or its item moves on
	assign en_s5 = !v_s5 || dout.ready;
	assign en_s4 = !v_s4 || en_s5;
	assign en_s3 = !v_s3 || en_s4;
	assign en_s2 = !v_s2 || en_s3;
	assign en_s1 = !v_s1 || en_s2;
	assign din.ready = en_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else begin
			if (en_s1) begin
				v_s1 <= din.valid;
			end
			if (en_s2) begin
				v_s2 <= v_s1;
			end
			if (en_s3) begin
				v_s3 <= v_s2;
			end
			if (en_s4) begin
				v_s4 <= v_s3;
			end
			if (en_s5) begin
				v_s5 <= v_s4;
			end
		end
	end

	// stage 1: products of q with the pure quaternion (0,v)
	always_ff @(posedge clk) begin
		if (en_s1) begin
			q_s1[0]  <= din.quat_w;
			q_s1[1]  <= din.quat_x;
			q_s1[2]  <= din.quat_y;
			q_s1[3]  <= din.quat_z;
			p_s1[0]  <= PROD_W'(din.quat_x) * PROD_W'(din.vec_x);
			p_s1[1]  <= PROD_W'(din.quat_y) * PROD_W'(din.vec_y);
			p_s1[2]  <= PROD_W'(din.quat_z) * PROD_W'(din.vec_z);
			p_s1[3]  <= PROD_W'(din.quat_w) * PROD_W'(din.vec_x);
			p_s1[4]  <= PROD_W'(din.quat_y) * PROD_W'(din.vec_z);
			p_s1[5]  <= PROD_W'(din.quat_z) * PROD_W'(din.vec_y);
			p_s1[6]  <= PROD_W'(din.quat_w) * PROD_W'(din.vec_y);
			p_s1[7]  <= PROD_W'(din.quat_x) * PROD_W'(din.vec_z);
			p_s1[8]  <= PROD_W'(din.quat_z) * PROD_W'(din.vec_x);
			p_s1[9]  <= PROD_W'(din.quat_w) * PROD_W'(din.vec_z);
			p_s1[10] <= PROD_W'(din.quat_x) * PROD_W'(din.vec_y);
			p_s1[11] <= PROD_W'(din.quat_y) * PROD_W'(din.vec_x);
		end
	end

	// stage 2: T = q * (0,v)
	always_ff @(posedge clk) begin
		if (en_s2) begin
			q_s2    <= q_s1;
			t_s2[0] <= -T_W'(p_s1[0]) - T_W'(p_s1[1]) - T_W'(p_s1[2]);
			t_s2[1] <=  T_W'(p_s1[3]) + T_W'(p_s1[4]) - T_W'(p_s1[5]);
			t_s2[2] <=  T_W'(p_s1[6]) - T_W'(p_s1[7]) + T_W'(p_s1[8]);
			t_s2[3] <=  T_W'(p_s1[9]) + T_W'(p_s1[10]) - T_W'(p_s1[11]);
		end
	end

	// stage 3: products of T with q; conj signs are applied in the sums
	always_ff @(posedge clk) begin
		if (en_s3) begin
			qp_s3[0]  <= QP_W'(t_s2[0]) * QP_W'(q_s2[1]);
			qp_s3[1]  <= QP_W'(t_s2[1]) * QP_W'(q_s2[0]);
			qp_s3[2]  <= QP_W'(t_s2[2]) * QP_W'(q_s2[3]);
			qp_s3[3]  <= QP_W'(t_s2[3]) * QP_W'(q_s2[2]);
			qp_s3[4]  <= QP_W'(t_s2[0]) * QP_W'(q_s2[2]);
			qp_s3[5]  <= QP_W'(t_s2[1]) * QP_W'(q_s2[3]);
			qp_s3[6]  <= QP_W'(t_s2[2]) * QP_W'(q_s2[0]);
			qp_s3[7]  <= QP_W'(t_s2[3]) * QP_W'(q_s2[1]);
			qp_s3[8]  <= QP_W'(t_s2[0]) * QP_W'(q_s2[3]);
			qp_s3[9]  <= QP_W'(t_s2[1]) * QP_W'(q_s2[2]);
			qp_s3[10] <= QP_W'(t_s2[2]) * QP_W'(q_s2[1]);
			qp_s3[11] <= QP_W'(t_s2[3]) * QP_W'(q_s2[0]);
		end
	end

	// stage 4: vector part of T * conj(q)
	always_ff @(posedge clk) begin
		if (en_s4) begin
			r_s4[0] <= -R_W'(qp_s3[0]) + R_W'(qp_s3[1]) - R_W'(qp_s3[2]) + R_W'(qp_s3[3]);
			r_s4[1] <= -R_W'(qp_s3[4]) + R_W'(qp_s3[5]) + R_W'(qp_s3[6]) - R_W'(qp_s3[7]);
			r_s4[2] <= -R_W'(qp_s3[8]) - R_W'(qp_s3[9]) + R_W'(qp_s3[10]) + R_W'(qp_s3[11]);
		end
	end

	// stage 5: round, saturate, output register
	for (genvar i = 0; i < 3; i++) begin : g_fin
		qrv_round_sat u_round_sat (
			.acc  (r_s4[i]),
			.rot  (rot_c[i]),
			.clip (clip_c[i])
		);
	end

	always_ff @(posedge clk) begin
		if (en_s5) begin
			rot_s5[0] <= rot_c[0];
			rot_s5[1] <= rot_c[1];
			rot_s5[2] <= rot_c[2];
			clip_s5   <= clip_c[0] || clip_c[1] || clip_c[2];
		end
	end

	assign dout.valid   = v_s5;
	assign dout.rot_x   = rot_s5[0];
	assign dout.rot_y   = rot_s5[1];
	assign dout.rot_z   = rot_s5[2];
	assign dout.clipped = clip_s5;

	`ASSERT_IMPL(a_in_ready_when_s1_empty, !v_s1, din.ready, "input stalled with stage 1 empty")
	`ASSERT_NEXT(a_s4_moves_out, v_s4 && en_s5, dout.valid, "stage 4 item lost on advance")
	`ASSERT_IMPL(a_clip_at_bound, dout.valid && dout.clipped,
		dout.rot_x == COMP_MAX || dout.rot_x == COMP_MIN || dout.rot_y == COMP_MAX ||
		dout.rot_y == COMP_MIN || dout.rot_z == COMP_MAX || dout.rot_z == COMP_MIN,
		"clipped flag set with no component at a bound")

endmodule

// ===== bench/tb_quaternion_rotate_vector.sv =====
`timescale 1ns / 100ps

module tb_quaternion_rotate_vector;
	import qrv_pkg::*;

	localparam int CYCLE_LIMIT = 200000;
	localparam int DRAIN_CYCLES = 12;

	typedef struct {
		comp_t qw;
		comp_t qx;
		comp_t qy;
		comp_t qz;
		comp_t vx;
		comp_t vy;
		comp_t vz;
	} rot_request_t;

	typedef struct {
		comp_t rx;
		comp_t ry;
		comp_t rz;
		logic  clip;
	} rot_vector_t;

	typedef enum int { IDLE_NONE, IDLE_RANDOM } idle_mode_t;

	logic clk = 1'b0;
	logic arst_n;

	qrv_in_if  din_if ();
	qrv_out_if dout_if ();

	quaternion_rotate_vector DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.din    (din_if),
		.dout   (dout_if)
	);

	rot_vector_t pending_rot[$];
	int          mismatch_count = 0;
	int          cycle_count = 0;
	idle_mode_t  send_idle = IDLE_NONE;
	idle_mode_t  recv_idle = IDLE_NONE;
	int          hold_tag = 0;
	int          hold_len = 0;

	always #2 clk = ~clk;

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results outstanding", cycle_count,
				pending_rot.size());
			$display("== FAIL ==");
			$finish;
		end
	end

	// exact q * (0,v) * conj(q); intermediates stay well under 64 bits
	function automatic rot_vector_t predict_rotation(rot_request_t req);
		longint w, x, y, z, vx, vy, vz;
		longint tw, tx, ty, tz;
		longint acc[3];
		longint sh;
		comp_t  comp[3];
		rot_vector_t res;
		w = longint'(req.qw);
		x = longint'(req.qx);
		y = longint'(req.qy);
		z = longint'(req.qz);
		vx = longint'(req.vx);
		vy = longint'(req.vy);
		vz = longint'(req.vz);
		tw = -(x * vx) - (y * vy) - (z * vz);
		tx = w * vx + y * vz - z * vy;
		ty = w * vy - x * vz + z * vx;
		tz = w * vz + x * vy - y * vx;
		acc[0] = tw * (-x) + tx * w + ty * (-z) + tz * y;
		acc[1] = tw * (-y) + tx * z + ty * w + tz * (-x);
		acc[2] = tw * (-z) + tx * (-y) + ty * x + tz * w;
		res.clip = 1'b0;
		for (int i = 0; i < 3; i++) begin
			// round half toward plus infinity, then clamp
			sh = (acc[i] + (64'sd1 <<< (2 * FRAC_BITS - 1))) >>> (2 * FRAC_BITS);
			if (sh > longint'(COMP_MAX)) begin
				sh = longint'(COMP_MAX);
				res.clip = 1'b1;
			end else if (sh < longint'(COMP_MIN)) begin
				sh = longint'(COMP_MIN);
				res.clip = 1'b1;
			end
			comp[i] = comp_t'(sh);
		end
		res.rx = comp[0];
		res.ry = comp[1];
		res.rz = comp[2];
		return res;
	endfunction

	function automatic int pick_gap(idle_mode_t mode);
		int r;
		if (mode == IDLE_NONE)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		if (r < 98)
			return $urandom_range(4, 10);
		return $urandom_range(20, 40);
	endfunction

	// span 0 means the whole signed range
	function automatic comp_t rand_comp(int span);
		if (span == 0)
			return comp_t'($urandom());
		return comp_t'(int'($urandom_range(0, 2 * span)) - span);
	endfunction

	function automatic rot_request_t make_request(int qw, int qx, int qy, int qz,
		int vx, int vy, int vz);
		rot_request_t req;
		req.qw = comp_t'(qw);
		req.qx = comp_t'(qx);
		req.qy = comp_t'(qy);
		req.qz = comp_t'(qz);
		req.vx = comp_t'(vx);
		req.vy = comp_t'(vy);
		req.vz = comp_t'(vz);
		return req;
	endfunction

	function automatic rot_request_t random_request();
		rot_request_t req;
		int qspan;
		case ($urandom_range(0, 3))
			0: qspan = 0;
			1: qspan = 16384;
			2: qspan = 9460;
			default: qspan = 2048;
		endcase
		req.qw = rand_comp(qspan);
		req.qx = rand_comp(qspan);
		req.qy = rand_comp(qspan);
		req.qz = rand_comp(qspan);
		req.vx = rand_comp(0);
		req.vy = rand_comp(0);
		req.vz = rand_comp(0);
		return req;
	endfunction

	task automatic send_rotation(rot_request_t req);
		int gap;
		gap = pick_gap(send_idle);
		if (gap > 0) begin
			din_if.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		din_if.valid <= 1'b1;
		din_if.quat_w <= req.qw;
		din_if.quat_x <= req.qx;
		din_if.quat_y <= req.qy;
		din_if.quat_z <= req.qz;
		din_if.vec_x <= req.vx;
		din_if.vec_y <= req.vy;
		din_if.vec_z <= req.vz;
		do
			@(posedge clk);
		while (!din_if.ready);
		pending_rot.push_back(predict_rotation(req));
	endtask

	task automatic send_random(int count);
		repeat (count) send_rotation(random_request());
	endtask

	// receiver: random stalls plus an occasional long hold-off on request
	initial begin
		int stall_left;
		int seen_tag;
		stall_left = 0;
		seen_tag = 0;
		dout_if.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_tag != seen_tag) begin
				seen_tag = hold_tag;
				stall_left = hold_len;
			end
			if (stall_left > 0) begin
				dout_if.ready <= 1'b0;
				stall_left--;
			end else begin
				dout_if.ready <= 1'b1;
				stall_left = pick_gap(recv_idle);
			end
		end
	end

	always @(posedge clk) begin
		rot_vector_t exp_rot;
		if (arst_n && dout_if.valid && dout_if.ready) begin
			if (pending_rot.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= 10)
					$display("unexpected result x=%0d y=%0d z=%0d clip=%0b",
						dout_if.rot_x, dout_if.rot_y, dout_if.rot_z, dout_if.clipped);
			end else begin
				exp_rot = pending_rot.pop_front();
				if (dout_if.rot_x !== exp_rot.rx || dout_if.rot_y !== exp_rot.ry ||
					dout_if.rot_z !== exp_rot.rz || dout_if.clipped !== exp_rot.clip) begin
					mismatch_count++;
					if (mismatch_count <= 10)
						$display("expected %0d %0d %0d clip %0b, got %0d %0d %0d clip %0b",
							exp_rot.rx, exp_rot.ry, exp_rot.rz, exp_rot.clip,
							dout_if.rot_x, dout_if.rot_y, dout_if.rot_z, dout_if.clipped);
				end
			end
		end
	end

	task automatic test_directed_cases();
		send_idle = IDLE_NONE;
		recv_idle = IDLE_NONE;
		// identity with vector extremes
		send_rotation(make_request(16384, 0, 0, 0, 32767, -32768, 0));
		send_rotation(make_request(16384, 0, 0, 0, -1, 1, -32768));
		// zero quaternion
		send_rotation(make_request(0, 0, 0, 0, 32767, -32768, 12345));
		// half turns about each axis
		send_rotation(make_request(0, 16384, 0, 0, 1000, -2000, 3000));
		send_rotation(make_request(0, 0, 16384, 0, 1000, -2000, 3000));
		send_rotation(make_request(0, 0, 0, 16384, 1000, -2000, 3000));
		// quarter turns, not quite unit length
		send_rotation(make_request(11585, 0, 0, 11585, 20000, 0, -7));
		send_rotation(make_request(11585, -11585, 0, 0, 0, 20000, 5));
		send_rotation(make_request(11585, 0, 11585, 0, -3, 7, 30000));
		// exact halves: w^2 = 2^26 so each unit of vx is a quarter
		send_rotation(make_request(8192, 0, 0, 0, -2, 2, -3));
		send_rotation(make_request(8192, 0, 0, 0, 1, -1, 3));
		send_rotation(make_request(-8192, 0, 0, 0, -6, 6, -5));
		// non-unit scale and saturation
		send_rotation(make_request(32767, 0, 0, 0, 8192, -8192, 8191));
		send_rotation(make_request(32767, 0, 0, 0, 32767, -32768, 1));
		send_rotation(make_request(32767, 32767, 32767, 32767, 32767, 32767, 32767));
		// most negative everywhere
		send_rotation(make_request(-32768, -32768, -32768, -32768, -32768, -32768, -32768));
		send_rotation(make_request(-32768, 0, 0, 0, -32768, 0, 32767));
		send_rotation(make_request(0, -32768, 0, 0, 32767, -32768, 0));
		send_rotation(make_request(0, 0, -32768, 32767, -1, -1, -1));
		send_rotation(make_request(-16384, 0, 0, 0, 32767, -32768, 32767));
		// tiny quaternion rounds everything to zero; then one with all parts at 1.0
		send_rotation(make_request(1, -1, 1, -1, 32767, 32767, -32768));
		send_rotation(make_request(16384, 16384, 16384, 16384, 4096, -4096, 100));
	endtask

	task automatic test_back_to_back();
		send_idle = IDLE_NONE;
		recv_idle = IDLE_NONE;
		send_random(300);
	endtask

	task automatic test_random_idling();
		send_idle = IDLE_RANDOM;
		recv_idle = IDLE_RANDOM;
		send_random(500);
	endtask

	task automatic test_output_hold_off();
		send_idle = IDLE_NONE;
		recv_idle = IDLE_NONE;
		// hold the output long enough that the pipeline fills and input stalls
		hold_len = 300;
		hold_tag++;
		send_random(100);
		recv_idle = IDLE_RANDOM;
		hold_len = 150;
		hold_tag++;
		send_random(60);
	endtask

	task automatic test_mixed_idling();
		send_idle = IDLE_RANDOM;
		recv_idle = IDLE_NONE;
		send_random(200);
		send_idle = IDLE_NONE;
		recv_idle = IDLE_RANDOM;
		send_random(200);
		send_idle = IDLE_RANDOM;
		recv_idle = IDLE_RANDOM;
		send_random(100);
	endtask

	initial begin
		arst_n = 1'b0;
		din_if.valid <= 1'b0;
		din_if.quat_w <= '0;
		din_if.quat_x <= '0;
		din_if.quat_y <= '0;
		din_if.quat_z <= '0;
		din_if.vec_x <= '0;
		din_if.vec_y <= '0;
		din_if.vec_z <= '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed_cases();
		test_back_to_back();
		test_random_idling();
		test_output_hold_off();
		test_mixed_idling();

		din_if.valid <= 1'b0;
		while (pending_rot.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (mismatch_count == 0) begin
			$display("== PASS ==");
		end else begin
			$display("%0d mismatches", mismatch_count);
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule

// ===== filelist.f =====
+incdir+rtl/core
rtl/core/qrv_pkg.sv
rtl/core/qrv_in_if.sv
rtl/core/qrv_out_if.sv
rtl/core/qrv_round_sat.sv
rtl/core/quaternion_rotate_vector.sv
bench/tb_quaternion_rotate_vector.sv
